FILE: rtl/core/assert_macros.svh
// Assertion macros used by the RTL core of the timestamp converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks an implication on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks that a beat entering the pipeline leaves it after the delay given by n.
`define ASSERT_DELAY(lbl, clk, rst, cause, n, effect, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cause) |-> ##n (effect)) \
    else $error(msg);

`endif

FILE: rtl/core/u2fat_pkg.sv
// Constants and helper functions for the Unix time to FAT timestamp converter.
package u2fat_pkg;

  // Reciprocal of 15 scaled by 2**34; exact for dividends below 2**30.
  localparam logic [30:0] RECIP15     = 31'd1145324613;
  localparam int          RECIP15_SH  = 34;
  // Reciprocal of 3 scaled by 2**20; exact for dividends below 2**19.
  localparam logic [18:0] RECIP3      = 19'd349526;
  localparam int          RECIP3_SH   = 20;
  // Reciprocal of 1461 scaled by 2**27; exact for dividends below 2**16.
  localparam logic [16:0] RECIP1461   = 17'd91868;
  localparam int          RECIP1461_SH = 27;

  localparam logic [10:0] DAYS_4Y     = 11'd1461;
  localparam logic [10:0] DAYS_COMMON = 11'd365;
  // Days from 1970-01-01 to 2100-03-01; from there on one day is inserted so
  // that the plain four-year rule also covers 2100, which is not a leap year.
  localparam logic [15:0] DAY_2100_MAR1 = 16'd47541;
  // Years between 1969 (start of the four-year count) and 1980.
  localparam logic [7:0]  YEARS_TO_FAT_BASE = 8'd11;

  // Day of year, counted from zero, on which month m (0 = January) starts.
  function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
    logic [8:0] base;
    begin
      case (m)
        4'd0:    base = 9'd0;
        4'd1:    base = 9'd31;
        4'd2:    base = 9'd59;
        4'd3:    base = 9'd90;
        4'd4:    base = 9'd120;
        4'd5:    base = 9'd151;
        4'd6:    base = 9'd181;
        4'd7:    base = 9'd212;
        4'd8:    base = 9'd243;
        4'd9:    base = 9'd273;
        4'd10:   base = 9'd304;
        4'd11:   base = 9'd334;
        default: base = 9'd0;
      endcase
      if (leap && (m >= 4'd2)) begin
        base = base + 9'd1;
      end
      return base;
    end
  endfunction

endpackage

FILE: rtl/core/unix_time_to_fat_timestamp_core.sv
// Pipelined converter from a Unix seconds count to packed FAT date and time words.
//
// Usage:
//   A beat enters on unix_seconds at every rising edge where start is high and
//   busy is low. busy never rises, so a new beat may enter in every cycle.
//   The converted fat_date and fat_time appear together with a one-cycle
//   strobe. Throughput is one beat per cycle; the ten register stages are
//   the input capture, three reciprocal multiplies for the divisions by
//   60, 60 and 24, the hour and day shift, a reciprocal multiply for the
//   four-year cycle, its remainder, the year within the cycle, the month
//   compare and the day subtract. The receiver cannot stall the pipeline:
//   every result is shown for exactly one cycle and must be taken then.
//   The year is found with four-year cycles counted from 1969; from
//   2100-03-01 on, the day count is bumped by one so that the missing leap
//   day of 2100 is accounted for.
//   A zero input, or any date before 1980, gives both words zero.
//   Reset (rst, synchronous, active high) clears all stage valid bits and the
//   strobe; beats in flight are dropped. There is no configuration.
`include "assert_macros.svh"

module unix_time_to_fat_timestamp_core
  import u2fat_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] unix_seconds,
  output logic        strobe,
  output logic [15:0] fat_date,
  output logic [15:0] fat_time
);

  localparam int LATENCY = 10;

  // Valid bits travel alongside the data, one per stage.
  logic [8:0] vld;

  // Stage 0: captured input.
  logic [31:0] s0_t;

  // Stage 1: seconds / 60.
  logic [31:0] s1_t;
  logic [26:0] s1_q1;
  logic        s1_zero;

  // Stage 2: seconds of minute, minutes / 60.
  logic [5:0]  s2_sec;
  logic [26:0] s2_q1;
  logic [20:0] s2_q2;
  logic        s2_zero;

  // Stage 3: minute of hour, hours / 24.
  logic [5:0]  s3_sec;
  logic [5:0]  s3_min;
  logic [20:0] s3_q2;
  logic [15:0] s3_days;
  logic        s3_zero;

  // Stage 4: hour of day, day count shifted to start in 1969.
  logic [5:0]  s4_sec;
  logic [5:0]  s4_min;
  logic [4:0]  s4_hr;
  logic [15:0] s4_dp;
  logic        s4_zero;

  // Stage 5: four-year cycle index.
  logic [5:0]  s5_sec;
  logic [5:0]  s5_min;
  logic [4:0]  s5_hr;
  logic [15:0] s5_dp;
  logic [5:0]  s5_cyc;
  logic        s5_zero;

  // Stage 6: day within the four-year cycle.
  logic [5:0]  s6_sec;
  logic [5:0]  s6_min;
  logic [4:0]  s6_hr;
  logic [5:0]  s6_cyc;
  logic [10:0] s6_r;
  logic        s6_zero;

  // Stage 7: year offset, leap flag and day of year.
  logic [5:0]  s7_sec;
  logic [5:0]  s7_min;
  logic [4:0]  s7_hr;
  logic [6:0]  s7_yoff;
  logic        s7_leap;
  logic [8:0]  s7_doy;
  logic        s7_zero;

  // Stage 8: month index.
  logic [5:0]  s8_sec;
  logic [5:0]  s8_min;
  logic [4:0]  s8_hr;
  logic [6:0]  s8_yoff;
  logic        s8_leap;
  logic [8:0]  s8_doy;
  logic [3:0]  s8_mon;
  logic        s8_zero;

  // Combinational values between stages.
  logic [60:0] prod1;
  logic [26:0] q1_next;
  logic [5:0]  sec_next;
  logic [32:0] q1x60;
  logic [55:0] prod2;
  logic [20:0] q2_next;
  logic [26:0] q2x60;
  logic [5:0]  min_next;
  logic [36:0] prod3;
  logic [15:0] days_next;
  logic [20:0] days_x24;
  logic [4:0]  hr_next;
  logic [15:0] dp_next;
  logic [32:0] prod4;
  logic [5:0]  cyc_next;
  logic [15:0] cyc_days;
  logic [10:0] r_next;
  logic [1:0]  yic;
  logic [10:0] yic_days;
  logic [8:0]  doy_next;
  logic [7:0]  y4;
  logic        pre_base;
  logic [3:0]  mon_next;
  logic [8:0]  day_ofs;
  logic [4:0]  day_next;

  assign busy = 1'b0;

  always_comb begin
    // Divide by 60 as a shift by 2 and a reciprocal multiply by 1/15.
    prod1   = 61'(s0_t[31:2]) * 61'(RECIP15);
    q1_next = prod1[60:RECIP15_SH];

    // Remainders below 64 only need the low six bits.
    q1x60    = {s1_q1, 6'b0} - {4'b0, s1_q1, 2'b0};
    sec_next = s1_t[5:0] - q1x60[5:0];
    prod2    = 56'(s1_q1[26:2]) * 56'(RECIP15);
    q2_next  = prod2[54:RECIP15_SH];

    q2x60     = {s2_q2, 6'b0} - {4'b0, s2_q2, 2'b0};
    min_next  = s2_q1[5:0] - q2x60[5:0];
    prod3     = 37'(s2_q2[20:3]) * 37'(RECIP3);
    days_next = prod3[35:RECIP3_SH];

    days_x24 = {2'b0, s3_days, 3'b0} + {1'b0, s3_days, 4'b0};
    hr_next  = s3_q2[4:0] - days_x24[4:0];
    dp_next  = s3_days + 16'(DAYS_COMMON)
             + ((s3_days >= DAY_2100_MAR1) ? 16'd1 : 16'd0);

    prod4    = 33'(s4_dp) * 33'(RECIP1461);
    cyc_next = prod4[32:RECIP1461_SH];

    cyc_days = 16'(s5_cyc) * 16'(DAYS_4Y);
    r_next   = s5_dp[10:0] - cyc_days[10:0];

    // The fourth year of each cycle is the leap year.
    if (s6_r >= 11'd1095) begin
      yic = 2'd3;
    end else if (s6_r >= 11'd730) begin
      yic = 2'd2;
    end else if (s6_r >= DAYS_COMMON) begin
      yic = 2'd1;
    end else begin
      yic = 2'd0;
    end
    yic_days = 11'(yic) * DAYS_COMMON;
    doy_next = 9'(s6_r - yic_days);
    y4       = {s6_cyc, yic};
    pre_base = (y4 < YEARS_TO_FAT_BASE);

    // Month is the number of later month starts already reached.
    mon_next = 4'd0;
    for (int m = 1; m < 12; m++) begin
      if (s7_doy >= month_start(4'(m), s7_leap)) begin
        mon_next = mon_next + 4'd1;
      end
    end

    day_ofs  = s8_doy - month_start(s8_mon, s8_leap) + 9'd1;
    day_next = day_ofs[4:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      strobe <= 1'b0;
    end else begin
      vld    <= {vld[7:0], start & ~busy};
      strobe <= vld[8];
    end
  end

  always_ff @(posedge clk) begin
    s0_t <= unix_seconds;

    s1_t    <= s0_t;
    s1_q1   <= q1_next;
    s1_zero <= (s0_t == 32'd0);

    s2_sec  <= sec_next;
    s2_q1   <= s1_q1;
    s2_q2   <= q2_next;
    s2_zero <= s1_zero;

    s3_sec  <= s2_sec;
    s3_min  <= min_next;
    s3_q2   <= s2_q2;
    s3_days <= days_next;
    s3_zero <= s2_zero;

    s4_sec  <= s3_sec;
    s4_min  <= s3_min;
    s4_hr   <= hr_next;
    s4_dp   <= dp_next;
    s4_zero <= s3_zero;

    s5_sec  <= s4_sec;
    s5_min  <= s4_min;
    s5_hr   <= s4_hr;
    s5_dp   <= s4_dp;
    s5_cyc  <= cyc_next;
    s5_zero <= s4_zero;

    s6_sec  <= s5_sec;
    s6_min  <= s5_min;
    s6_hr   <= s5_hr;
    s6_cyc  <= s5_cyc;
    s6_r    <= r_next;
    s6_zero <= s5_zero;

    s7_sec  <= s6_sec;
    s7_min  <= s6_min;
    s7_hr   <= s6_hr;
    s7_yoff <= 7'(y4 - YEARS_TO_FAT_BASE);
    s7_leap <= (yic == 2'd3);
    s7_doy  <= doy_next;
    s7_zero <= s6_zero | pre_base;

    s8_sec  <= s7_sec;
    s8_min  <= s7_min;
    s8_hr   <= s7_hr;
    s8_yoff <= s7_yoff;
    s8_leap <= s7_leap;
    s8_doy  <= s7_doy;
    s8_mon  <= mon_next;
    s8_zero <= s7_zero;

    if (s8_zero) begin
      fat_date <= '0;
      fat_time <= '0;
    end else begin
      fat_date <= {s8_yoff, s8_mon + 4'd1, day_next};
      fat_time <= {s8_hr, s8_min, s8_sec[5:1]};
    end
  end

  // Every accepted beat gives exactly one strobe after the pipeline latency.
  `ASSERT_DELAY(a_latency, clk, rst, start && !busy, LATENCY, strobe, "result strobe missing")
  // A valid time word never holds an hour, minute or half-second out of range.
  `ASSERT_CLK(a_time_range, clk, rst, strobe |-> (fat_time[15:11] < 5'd24) && (fat_time[10:5] < 6'd60) && (fat_time[4:0] < 5'd30), "time field out of range")
  // A nonzero date word holds a month of 1 to 12 and a nonzero day.
  `ASSERT_CLK(a_date_range, clk, rst, (strobe && (fat_date != 16'd0)) |-> (fat_date[8:5] >= 4'd1) && (fat_date[8:5] <= 4'd12) && (fat_date[4:0] != 5'd0), "date field out of range")

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the Unix time to FAT timestamp converter.
module tb;

  // One converted timestamp: the two packed words of a FAT directory entry.
  typedef struct packed {
    logic [15:0] fat_date;
    logic [15:0] fat_time;
  } fat_stamp_t;

  // One directed row. Where known is set, the expected words are typed in
  // by hand; otherwise the predictor works them out.
  typedef struct packed {
    logic [31:0] secs;
    bit          known;
    logic [15:0] date_word;
    logic [15:0] time_word;
  } stamp_row_t;

  localparam int unsigned EPOCH_YEAR    = 1970;
  localparam int unsigned FAT_BASE_YEAR = 1980;
  localparam int unsigned SECS_PER_DAY  = 86400;
  localparam int          NUM_DIRECTED  = 21;
  localparam int          RANDOM_BEATS  = 1500;
  localparam int          DRAIN_CYCLES  = 30;
  localparam int          MAX_REPORTS   = 10;
  // The slowest correct run is the phase with 69 percent idle; this limit
  // allows far more cycles than the whole run needs.
  localparam int          CYCLE_LIMIT   = 200000;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [31:0] unix_seconds;
  logic        strobe;
  logic [15:0] fat_date;
  logic [15:0] fat_time;

  // Words still owed by the converter, oldest first.
  fat_stamp_t  owed_stamps[$];
  stamp_row_t  directed_rows [0:NUM_DIRECTED-1];

  int unsigned month_len [0:11] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  int          cycle_count;
  int          fail_count;
  int          mismatch_count;
  int          beats_sent;
  int          stamps_seen;
  int          zero_stamps;

  unix_time_to_fat_timestamp_core dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .unix_seconds (unix_seconds),
    .strobe       (strobe),
    .fat_date     (fat_date),
    .fat_time     (fat_time)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Gregorian rule: every fourth year, but centuries only when divisible by 400.
  function automatic bit leap_year(input int unsigned yr);
    return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
  endfunction

  function automatic int unsigned year_days(input int unsigned yr);
    return leap_year(yr) ? 366 : 365;
  endfunction

  // Converts a seconds count the slow way: peel off seconds, minutes and
  // hours, then walk whole years from 1970 and whole months within the year.
  function automatic fat_stamp_t unix_to_fat(input logic [31:0] secs);
    fat_stamp_t  stamp;
    int unsigned days;
    int unsigned sec;
    int unsigned min;
    int unsigned hr;
    int unsigned yr;
    int unsigned mon;
    int unsigned mlen;
    stamp = '0;
    if (secs == 32'd0) begin
      return stamp;
    end
    sec  = secs % 60;
    days = secs / 60;
    min  = days % 60;
    days = days / 60;
    hr   = days % 24;
    days = days / 24;
    yr   = EPOCH_YEAR;
    while (days >= year_days(yr)) begin
      days = days - year_days(yr);
      yr++;
    end
    // Dates before the FAT epoch cannot be represented; both words stay zero.
    if (yr < FAT_BASE_YEAR) begin
      return stamp;
    end
    mon = 0;
    while (mon < 11) begin
      mlen = (mon == 1 && leap_year(yr)) ? 29 : month_len[mon];
      if (days < mlen) begin
        break;
      end
      days = days - mlen;
      mon++;
    end
    stamp.fat_date = 16'(((yr - FAT_BASE_YEAR) << 9) | ((mon + 1) << 5) | ((days + 1) & 31));
    stamp.fat_time = 16'((hr << 11) | (min << 5) | (sec / 2));
    return stamp;
  endfunction

  // Random seconds count. Most draws land in the representable range, a
  // good share sits right on year and leap-day boundaries, and the rest is
  // zero, pre-1980 or fully random.
  function automatic logic [31:0] random_seconds();
    int unsigned pick;
    int unsigned yr;
    int unsigned day;
    int unsigned y;
    pick = $urandom_range(99);
    if (pick < 2) begin
      return 32'd0;
    end else if (pick < 10) begin
      return $urandom_range(315532799, 1);
    end else if (pick < 35) begin
      yr  = $urandom_range(2105, 1980);
      day = 0;
      for (y = EPOCH_YEAR; y < yr; y++) begin
        day = day + year_days(y);
      end
      // Last day of the year before, New Year's Day, February 28th,
      // March 1st, or the last day of the year.
      case ($urandom_range(4))
        0:       day = day - 1;
        1:       day = day;
        2:       day = day + 58;
        3:       day = day + 59 + (leap_year(yr) ? 1 : 0);
        default: day = day + year_days(yr) - 1;
      endcase
      return 32'(day * SECS_PER_DAY + $urandom_range(SECS_PER_DAY - 1));
    end else if (pick < 85) begin
      return $urandom_range(32'hFFFF_FFFF, 315532800);
    end else begin
      return $urandom();
    end
  endfunction

  // Presents one beat from the falling edge on and waits for the rising
  // edge that takes it. start stays high on return, so a following beat
  // goes out back to back.
  task automatic send_beat(input logic [31:0] secs, input bit known, input fat_stamp_t typed);
    @(negedge clk);
    start        <= 1'b1;
    unix_seconds <= secs;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
    owed_stamps.push_back(known ? typed : unix_to_fat(secs));
    beats_sent++;
  endtask

  // Leaves the input idle for a random number of cycles; each further idle
  // cycle follows with the given chance in percent.
  task automatic idle_gap(input int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Lowers start and holds off until every owed stamp has come out.
  task automatic drain_owed();
    @(negedge clk);
    start <= 1'b0;
    while (owed_stamps.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Result side: the converter shows each stamp for one cycle only, so it is
  // taken on the rising edge that closes the strobe cycle and matched
  // against the oldest stamp still owed.
  always @(posedge clk) begin
    fat_stamp_t want;
    if (!rst && strobe) begin
      stamps_seen++;
      if (owed_stamps.size() == 0) begin
        fail_count++;
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("Unexpected stamp: date %h time %h", fat_date, fat_time);
        end
      end else begin
        want = owed_stamps.pop_front();
        if (want == '0) begin
          zero_stamps++;
        end
        if (fat_date !== want.fat_date || fat_time !== want.fat_time) begin
          fail_count++;
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("Stamp %0d mismatch: date %h (expected %h), time %h (expected %h)",
                     stamps_seen, fat_date, want.fat_date, fat_time, want.fat_time);
          end
        end
      end
    end
  end

  // Watchdog against a hung converter.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d stamps owed",
               cycle_count, owed_stamps.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int          pct_idx;
    int          n;
    int unsigned idle_pct;
    int unsigned phase_pct [0:3];
    rst            = 1'b1;
    start          = 1'b0;
    unix_seconds   = 32'd0;
    cycle_count    = 0;
    fail_count     = 0;
    mismatch_count = 0;
    beats_sent     = 0;
    stamps_seen    = 0;
    zero_stamps    = 0;
    // Sender idle rates per random phase; the receiver cannot stall here, so
    // its phases reduce to a second run with the sender always ready.
    phase_pct      = '{0, 69, 0, 20};

    // Edge cases. Rows with known set carry words that follow directly from
    // the definition: zero input, dates before 1980, the FAT epoch itself and
    // the very last representable second (2106-02-07 06:28:15).
    directed_rows = '{
      '{32'd0,          1'b1, 16'h0000, 16'h0000},
      '{32'd1,          1'b1, 16'h0000, 16'h0000},
      '{32'd86399,      1'b1, 16'h0000, 16'h0000},
      '{32'd315532799,  1'b1, 16'h0000, 16'h0000},
      '{32'd315532800,  1'b1, 16'h0021, 16'h0000},
      '{32'hFFFF_FFFF,  1'b1, 16'hFC47, 16'h3387},
      '{32'd315532801,  1'b0, 16'h0000, 16'h0000},  // odd second rounds down
      '{32'hFFFF_FFFE,  1'b0, 16'h0000, 16'h0000},
      '{32'd320630400,  1'b0, 16'h0000, 16'h0000},  // 1980-02-29
      '{32'd951782400,  1'b0, 16'h0000, 16'h0000},  // 2000-02-29, century leap year
      '{32'd951868800,  1'b0, 16'h0000, 16'h0000},  // 2000-03-01
      '{32'd978307199,  1'b0, 16'h0000, 16'h0000},  // 2000-12-31 23:59:59
      '{32'd4102444800, 1'b0, 16'h0000, 16'h0000},  // 2100-01-01
      '{32'd4107456000, 1'b0, 16'h0000, 16'h0000},  // 2100-02-28, no leap day
      '{32'd4107542399, 1'b0, 16'h0000, 16'h0000},
      '{32'd4107542400, 1'b0, 16'h0000, 16'h0000},  // 2100-03-01
      '{32'h8000_0000,  1'b0, 16'h0000, 16'h0000},
      '{32'h7FFF_FFFF,  1'b0, 16'h0000, 16'h0000},
      '{32'h5555_5555,  1'b0, 16'h0000, 16'h0000},
      '{32'hAAAA_AAAA,  1'b0, 16'h0000, 16'h0000},
      '{32'd1700000000, 1'b0, 16'h0000, 16'h0000}
    };

    repeat (11) @(negedge clk);
    rst <= 1'b0;

    for (n = 0; n < NUM_DIRECTED; n++) begin
      send_beat(directed_rows[n].secs, directed_rows[n].known,
                {directed_rows[n].date_word, directed_rows[n].time_word});
    end
    // The sender waits here until the pipeline has emptied.
    drain_owed();

    // Random phases. Within each phase, the first quarter of every 64 beats
    // runs with no idling so that back-to-back stretches occur everywhere.
    for (pct_idx = 0; pct_idx < 4; pct_idx++) begin
      idle_pct = phase_pct[pct_idx];
      for (n = 0; n < RANDOM_BEATS / 4; n++) begin
        send_beat(random_seconds(), 1'b0, '0);
        if (n % 64 >= 16) begin
          idle_gap(idle_pct);
        end
      end
      drain_owed();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (owed_stamps.size() != 0) begin
      fail_count++;
      $display("%0d stamps never came out", owed_stamps.size());
    end
    $display("Sent %0d timestamps (%0d edge cases), %0d came back as zero words;",
             beats_sent, NUM_DIRECTED, zero_stamps);
    $display("sender idle rates of 0, 20 and 69 percent, %0d mismatches.", mismatch_count);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
